/* rtl/binary_to_decimal_ascii_assert.svh */
// Assertion macros for the converter's top level, which checks its own behaviour.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B2DA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b2da: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("b2da: next-cycle check failed");

`endif

/* rtl/b2da_pkg.sv */
`default_nettype none

package b2da_pkg;

   // Field widths of the channels.
   localparam int ValueBits = 64;
   localparam int CharBits  = 6;

   // Number of low bits of the value that are converted.
   localparam int ValueWidth = 64;

   // Decimal digits needed for ValueWidth bits; the ratio is rounded up so
   // the count is never short.
   localparam int DigitCount = (ValueWidth * 30103) / 100000 + 1;
   localparam int BcdWidth   = 4 * DigitCount;
   localparam int IdxWidth   = (DigitCount > 1) ? $clog2(DigitCount) : 1;
   localparam int CntWidth   = $clog2(ValueWidth + 1);

   localparam logic [CharBits-1:0] AsciiZero = CharBits'(48);

   // Microprogram addresses.
   typedef logic [1:0] step_type;
   localparam step_type StepLoad   = 2'd0;
   localparam step_type StepDabble = 2'd1;
   localparam step_type StepSkip   = 2'd2;
   localparam step_type StepEmit   = 2'd3;
   localparam int StepCount = 4;

   typedef enum logic [1:0] {
      OpLoad   = 2'd0,
      OpDabble = 2'd1,
      OpSkip   = 2'd2,
      OpEmit   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CondAccept     = 2'd0,
      CondCountZero  = 2'd1,
      CondDigitFound = 2'd2,
      CondEmitLast   = 2'd3
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic accept;
      logic count_zero;
      logic digit_found;
      logic emit_last;
   } status_type;

   // One control word per step: the step stays put until its condition is
   // met, then jumps to the target.
   localparam ctrl_word_type MicroProgram [StepCount] = '{
      '{op: OpLoad,   cond: CondAccept,     target: StepDabble},
      '{op: OpDabble, cond: CondCountZero,  target: StepSkip},
      '{op: OpSkip,   cond: CondDigitFound, target: StepEmit},
      '{op: OpEmit,   cond: CondEmitLast,   target: StepLoad}
   };

endpackage

`default_nettype wire

/* rtl/b2da_if.sv */
`default_nettype none

interface b2da_req_if import b2da_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ValueBits-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface b2da_rsp_if import b2da_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CharBits-1:0] digit_char;
   logic                last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

/* rtl/binary_to_decimal_ascii.sv */
// Unsigned binary to decimal ASCII text converter.
// The req channel carries one 64-bit value per transaction; only the low
// ValueWidth bits are converted. The rsp channel returns the decimal digits
// as ASCII characters, most significant first, leading zeros suppressed,
// one digit per transaction, with last_digit set on the final one. Zero
// gives the single character '0'.
// A small microprogram drives the datapath: load, one double-dabble bit per
// cycle, skipping of leading zeros one digit per cycle, then one digit
// emitted per cycle while the receiver is ready.
// One item is in work at a time: req_ready rises again as the last digit
// enters the output register, so the next value is taken while that digit
// still waits to be collected.
// A stalled receiver freezes the emit step; the held digit stays on rsp.
// Synchronous reset empties the output register and returns the sequencer
// to its load step; no other state needs clearing.
`default_nettype none

`include "binary_to_decimal_ascii_assert.svh"

module binary_to_decimal_ascii import b2da_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   b2da_req_if.sink   req,
   b2da_rsp_if.source rsp
);

   ctrl_word_type ctrl;
   status_type    status;

   b2da_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   b2da_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

   // A new value starts a conversion, so the input closes at once.
   `B2DA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
   // While waiting for input, a pending digit can only be the final one.
   `B2DA_ASSERT_SAME(a_idle_holds_last, req.ready && rsp.valid, rsp.last_digit)
   // After a digit that is not the last, the next digit is loaded at once.
   `B2DA_ASSERT_NEXT(a_run_continues, rsp.valid && rsp.ready && !rsp.last_digit, rsp.valid)

endmodule

`default_nettype wire

/* rtl/b2da_useq.sv */
`default_nettype none

module b2da_useq import b2da_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire status_type    status,
   output ctrl_word_type      ctrl
);

   step_type pc_ff;
   step_type pc_in;
   logic     cond_true;

   assign ctrl = MicroProgram[pc_ff];

   always_comb begin
      case (ctrl.cond)
         CondAccept:     cond_true = status.accept;
         CondCountZero:  cond_true = status.count_zero;
         CondDigitFound: cond_true = status.digit_found;
         CondEmitLast:   cond_true = status.emit_last;
         default:        cond_true = 1'b0;
      endcase
      pc_in = cond_true ? ctrl.target : pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= StepLoad;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/b2da_datapath.sv */
`default_nettype none

module b2da_datapath import b2da_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_word_type ctrl,
   output status_type         status,
   b2da_req_if.sink           req,
   b2da_rsp_if.source         rsp
);

   logic [ValueWidth-1:0] bin_ff,  bin_in;
   logic [BcdWidth-1:0]   bcd_ff,  bcd_in;
   logic [BcdWidth-1:0]   bcd_adj;
   logic [CntWidth-1:0]   cnt_ff,  cnt_in;
   logic [IdxWidth-1:0]   idx_ff,  idx_in;
   logic                  valid_ff, valid_in;
   logic [CharBits-1:0]   char_ff,  char_in;
   logic                  last_ff,  last_in;

   logic [3:0] top_digit;
   logic       idx_last;
   logic       slot_free;
   logic       accept;
   logic       emit;

   assign top_digit = bcd_ff[BcdWidth-1 -: 4];
   assign idx_last  = (idx_ff == IdxWidth'(DigitCount - 1));
   assign slot_free = !valid_ff || rsp.ready;
   assign req.ready = (ctrl.op == OpLoad);
   assign accept    = req.valid && req.ready;
   assign emit      = (ctrl.op == OpEmit) && slot_free;

   assign status.accept      = accept;
   assign status.count_zero  = (cnt_ff == '0);
   assign status.digit_found = (top_digit != 4'd0) || idx_last;
   assign status.emit_last   = emit && idx_last;

   // Every digit of five or more is corrected by three before the shift.
   always_comb begin
      for (int d = 0; d < DigitCount; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                         : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp.ready;
      case (ctrl.op)
         OpLoad: begin
            if (accept) begin
               bin_in = req.value[ValueWidth-1:0];
               bcd_in = '0;
               cnt_in = CntWidth'(ValueWidth - 1);
               idx_in = '0;
            end
         end
         OpDabble: begin
            bcd_in = {bcd_adj[BcdWidth-2:0], bin_ff[ValueWidth-1]};
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - 1'b1;
         end
         OpSkip: begin
            if (!status.digit_found) begin
               bcd_in = bcd_ff << 4;
               idx_in = idx_ff + 1'b1;
            end
         end
         OpEmit: begin
            if (emit) begin
               char_in  = AsciiZero + {{(CharBits-4){1'b0}}, top_digit};
               last_in  = idx_last;
               valid_in = 1'b1;
               bcd_in   = bcd_ff << 4;
               idx_in   = idx_ff + 1'b1;
            end
         end
         default: begin
            bin_in = bin_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.digit_char = char_ff;
   assign rsp.last_digit = last_ff;

endmodule

`default_nettype wire
